### design/frequency_residency_counter_core_macros.svh
// Assertion macros for the frequency residency counter.
// Every user must have clk and rst in scope, since the macros sample on clk and hold off in rst.
`ifndef FREQUENCY_RESIDENCY_COUNTER_CORE_MACROS_SVH
`define FREQUENCY_RESIDENCY_COUNTER_CORE_MACROS_SVH

// Check a property at every clock edge outside reset.
`define FRC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that a trigger is followed by a consequence in the next cycle.
`define FRC_ASSERT_NEXT(name, trig, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

### design/frc_pkg.sv
// Shared constants and handshake structs for the frequency residency counter.
// No dependencies; every other design file but the macro header imports this package.
`default_nettype none

package frc_pkg;

  localparam int MAX_STATES_DEF = 16;

  localparam int OP_W     = 2;
  localparam int FREQ_W   = 32;
  localparam int TS_W     = 64;
  localparam int RC_W     = 4;
  localparam int STATUS_W = 2;
  localparam int SIDX_W   = 4;
  localparam int CNT_W    = 32;

  localparam int S_TDATA_W = 104;
  localparam int M_TDATA_W = 168;

  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_START  = 2'd1;
  localparam logic [OP_W-1:0] OP_CHANGE = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  localparam logic [FREQ_W-1:0] FREQ_INVALID = 32'hFFFF_FFFE;
  localparam logic [FREQ_W-1:0] FREQ_END     = 32'hFFFF_FFFF;

  // Requests to the frequency table
  typedef struct packed {
    logic start;   // search loaded entries for the key
    logic load;    // append the key at the fill count
    logic rd_row;  // read the entry at the row address
  } frc_srch_req_t;

  typedef struct packed {
    logic done;
    logic found;
  } frc_srch_rsp_t;

  // Requests to the counter memories
  typedef struct packed {
    logic rd;       // read residency and cell at the given addresses
    logic wb_res;   // write back residency read plus delta
    logic wb_cell;  // write back cell read plus one
  } frc_cnt_req_t;

endpackage

`default_nettype wire

### design/frc_search.sv
// Frequency table memory with fill count and a sequential lookup over loaded entries.
// Depends on frc_pkg.
`default_nettype none

module frc_search import frc_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst,
  input  frc_srch_req_t                         req,
  input  wire  [FREQ_W-1:0]                     key,
  input  wire  [$clog2(MAX_STATES)-1:0]         row_addr,
  output frc_srch_rsp_t                         rsp,
  output logic [$clog2(MAX_STATES)-1:0]         idx,
  output logic [FREQ_W-1:0]                     q,
  output logic [$clog2(MAX_STATES+1)-1:0]       count
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int EW = $clog2(MAX_STATES + 1);
  localparam int DEPTH = 1 << IW;
  localparam logic [EW-1:0] MAX_CNT = EW'(MAX_STATES);

  logic [FREQ_W-1:0] mem [0:DEPTH-1];

  logic [EW-1:0] ptr;
  logic [IW-1:0] pend_idx;
  logic          busy;
  logic          pend;
  logic          done;
  logic          found;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;

  assign rd_en   = (busy && (ptr < count)) || req.rd_row;
  assign rd_addr = req.rd_row ? row_addr : ptr[IW-1:0];
  assign wr_en   = req.load && (count < MAX_CNT);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]] <= key;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  // Issue one address a cycle; compare the entry read on the cycle before.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      busy  <= 1'b0;
      pend  <= 1'b0;
      done  <= 1'b0;
      found <= 1'b0;
      ptr   <= '0;
    end else begin
      if (req.start) begin
        busy <= 1'b1;
        pend <= 1'b0;
        done <= 1'b0;
        ptr  <= '0;
      end else if (busy) begin
        if (pend && (q == key)) begin
          busy  <= 1'b0;
          done  <= 1'b1;
          found <= 1'b1;
          idx   <= pend_idx;
        end else if (ptr < count) begin
          pend     <= 1'b1;
          done     <= 1'b0;
          pend_idx <= ptr[IW-1:0];
          ptr      <= ptr + 1'b1;
        end else begin
          busy  <= 1'b0;
          done  <= 1'b1;
          found <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
      if (wr_en) begin
        count <= count + 1'b1;
      end
    end
  end

  assign rsp = '{done: done, found: found};

endmodule

`default_nettype wire

### design/frc_counts.sv
// Residency and transition counter memories with read-modify-write and a clearing pass.
// Depends on frc_pkg.
`default_nettype none

module frc_counts import frc_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  frc_cnt_req_t                       req,
  input  wire  [$clog2(MAX_STATES)-1:0]      res_addr,
  input  wire  [2*$clog2(MAX_STATES)-1:0]    cell_addr,
  input  wire  [TS_W-1:0]                    delta,
  output logic [TS_W-1:0]                    res_q,
  output logic [CNT_W-1:0]                   cell_q,
  output logic                               clearing
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int RES_DEPTH = 1 << IW;
  localparam int CELL_DEPTH = 1 << (2 * IW);
  localparam logic [2*IW-1:0] CLR_LAST = {(2 * IW){1'b1}};

  logic [TS_W-1:0]  res_mem  [0:RES_DEPTH-1];
  logic [CNT_W-1:0] cell_mem [0:CELL_DEPTH-1];

  logic [2*IW-1:0] clr_ptr;

  logic            res_we;
  logic [IW-1:0]   res_waddr;
  logic [TS_W-1:0] res_wdata;
  logic            cell_we;
  logic [2*IW-1:0] cell_waddr;
  logic [CNT_W-1:0] cell_wdata;

  // Clear both memories after reset; afterwards write back the last read plus an increment.
  assign res_we     = clearing || req.wb_res;
  assign res_waddr  = clearing ? clr_ptr[IW-1:0] : res_addr;
  assign res_wdata  = clearing ? '0 : res_q + delta;
  assign cell_we    = clearing || req.wb_cell;
  assign cell_waddr = clearing ? clr_ptr : cell_addr;
  assign cell_wdata = clearing ? '0 : cell_q + 1'b1;

  always_ff @(posedge clk) begin
    if (res_we) begin
      res_mem[res_waddr] <= res_wdata;
    end
    if (cell_we) begin
      cell_mem[cell_waddr] <= cell_wdata;
    end
    if (req.rd) begin
      res_q  <= res_mem[res_addr];
      cell_q <= cell_mem[cell_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_ptr  <= '0;
    end else if (clearing) begin
      clr_ptr <= clr_ptr + 1'b1;
      if (clr_ptr == CLR_LAST) begin
        clearing <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

### design/frequency_residency_counter_core.sv
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tuser: operation; tdata: frequency, timestamp, row, column
// m_*      out  m_tvalid/m_tready  tuser: status; tdata: state_index, residency, counts, entry
//
// One item at a time: a lookup that reads one table entry per cycle (a read skips it), then,
// where the item accrues, a read-modify-write of the counter memories, and a report read.
// Reset clears the counter memories in a pass over every cell address, during which no item
// is taken. A result waiting on m_tready does not block the next input; the block stalls
// only before loading a second result.
// Top level: sequencer around frc_search and frc_counts; depends on frc_pkg and the macro header.
`default_nettype none
`include "frequency_residency_counter_core_macros.svh"

module frequency_residency_counter_core import frc_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    s_tvalid,
  output logic                   s_tready,
  // [31:0] frequency, [95:32] timestamp, [99:96] row, [103:100] column
  input  wire  [S_TDATA_W-1:0]   s_tdata,
  // [1:0] operation
  input  wire  [OP_W-1:0]        s_tuser,
  output logic                   m_tvalid,
  input  wire                    m_tready,
  // [3:0] state_index, [67:4] residency, [99:68] transition_count,
  // [131:100] total_transitions, [163:132] entry_frequency, [167:164] zero
  output logic [M_TDATA_W-1:0]   m_tdata,
  // [1:0] status
  output logic [STATUS_W-1:0]    m_tuser
);

  localparam int IW = $clog2(MAX_STATES);
  localparam int EW = $clog2(MAX_STATES + 1);
  localparam int CW = (EW > RC_W) ? EW : RC_W;
  localparam logic [EW-1:0] MAX_CNT = EW'(MAX_STATES);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SEEK  = 3'd1;
  localparam logic [2:0] S_FIND  = 3'd2;
  localparam logic [2:0] S_APPLY = 3'd3;
  localparam logic [2:0] S_WB    = 3'd4;
  localparam logic [2:0] S_RD    = 3'd5;
  localparam logic [2:0] S_RDW   = 3'd6;

  logic [2:0]          state;
  logic [OP_W-1:0]     op_r;
  logic [FREQ_W-1:0]   freq_r;
  logic [TS_W-1:0]     ts_r;
  logic [RC_W-1:0]     row_r;
  logic [RC_W-1:0]     col_r;
  logic [IW-1:0]       cur;
  logic                known;
  logic [TS_W-1:0]     last_stamp;
  logic [CNT_W-1:0]    total;
  logic [STATUS_W-1:0] status_r;
  logic [IW-1:0]       idx_r;
  logic                found_r;
  logic                do_cell;
  logic [TS_W-1:0]     delta;

  frc_srch_req_t       srch_req;
  frc_srch_rsp_t       srch_rsp;
  logic [IW-1:0]       srch_idx;
  logic [FREQ_W-1:0]   tab_q;
  logic [EW-1:0]       count;

  frc_cnt_req_t        cnt_req;
  logic [IW-1:0]       res_addr;
  logic [2*IW-1:0]     cell_addr;
  logic [TS_W-1:0]     res_q;
  logic [CNT_W-1:0]    cell_q;
  logic                clearing;

  logic [IW-1:0]       row_idx;
  logic [IW-1:0]       col_idx;
  logic                row_ok;
  logic                col_ok;
  logic                marker;
  logic                load_ok;
  logic                accrue_go;
  logic                s_acc;
  logic                out_load;

  assign s_tready  = (state == S_IDLE) && !clearing;
  assign s_acc     = s_tvalid && s_tready;
  assign out_load  = (state == S_RDW) && (!m_tvalid || m_tready);

  assign row_idx   = IW'(row_r);
  assign col_idx   = IW'(col_r);
  assign row_ok    = CW'(row_r) < CW'(count);
  assign col_ok    = CW'(col_r) < CW'(count);
  assign marker    = (freq_r == FREQ_INVALID) || (freq_r == FREQ_END);
  assign load_ok   = !marker && !found_r && (count < MAX_CNT);
  assign accrue_go = known && ((op_r == OP_READ) || ((op_r == OP_CHANGE) && found_r));

  assign srch_req = '{
    start:  state == S_SEEK,
    load:   (state == S_APPLY) && (op_r == OP_LOAD) && load_ok,
    rd_row: state == S_RD
  };

  assign cnt_req = '{
    rd:      ((state == S_APPLY) && accrue_go) || (state == S_RD),
    wb_res:  state == S_WB,
    wb_cell: (state == S_WB) && do_cell
  };

  assign res_addr  = (state == S_RD) ? row_idx : cur;
  assign cell_addr = (state == S_RD) ? {row_idx, col_idx} : {cur, idx_r};

  frc_search #(
    .MAX_STATES(MAX_STATES)
  ) u_search (
    .clk      (clk),
    .rst      (rst),
    .req      (srch_req),
    .key      (freq_r),
    .row_addr (row_idx),
    .rsp      (srch_rsp),
    .idx      (srch_idx),
    .q        (tab_q),
    .count    (count)
  );

  frc_counts #(
    .MAX_STATES(MAX_STATES)
  ) u_counts (
    .clk       (clk),
    .rst       (rst),
    .req       (cnt_req),
    .res_addr  (res_addr),
    .cell_addr (cell_addr),
    .delta     (delta),
    .res_q     (res_q),
    .cell_q    (cell_q),
    .clearing  (clearing)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur        <= '0;
      known      <= 1'b0;
      last_stamp <= '0;
      total      <= '0;
      m_tvalid   <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            op_r   <= s_tuser;
            freq_r <= s_tdata[31:0];
            ts_r   <= s_tdata[95:32];
            row_r  <= s_tdata[99:96];
            col_r  <= s_tdata[103:100];
            state  <= (s_tuser == OP_READ) ? S_APPLY : S_SEEK;
          end
        end
        S_SEEK: begin
          state <= S_FIND;
        end
        S_FIND: begin
          if (srch_rsp.done) begin
            found_r <= srch_rsp.found;
            idx_r   <= srch_idx;
            state   <= S_APPLY;
          end
        end
        S_APPLY: begin
          case (op_r)
            OP_LOAD: begin
              if (marker || found_r) begin
                status_r <= ST_IGNORED;
              end else if (count < MAX_CNT) begin
                status_r <= ST_OK;
              end else begin
                status_r <= ST_FULL;
              end
              state <= S_RD;
            end
            OP_START: begin
              last_stamp <= ts_r;
              known      <= found_r;
              cur        <= found_r ? idx_r : '0;
              status_r   <= found_r ? ST_OK : ST_IGNORED;
              state      <= S_RD;
            end
            OP_CHANGE: begin
              if (accrue_go) begin
                status_r   <= ST_OK;
                delta      <= ts_r - last_stamp;
                last_stamp <= ts_r;
                do_cell    <= idx_r != cur;
                state      <= S_WB;
              end else begin
                status_r <= ST_IGNORED;
                state    <= S_RD;
              end
            end
            default: begin
              status_r   <= ST_OK;
              delta      <= ts_r - last_stamp;
              last_stamp <= ts_r;
              do_cell    <= 1'b0;
              state      <= accrue_go ? S_WB : S_RD;
            end
          endcase
        end
        S_WB: begin
          // Count the transition and move to the new state
          if (do_cell) begin
            total <= total + 1'b1;
            cur   <= idx_r;
          end
          state <= S_RD;
        end
        S_RD: begin
          state <= S_RDW;
        end
        S_RDW: begin
          // Hold here until the output register is free
          if (out_load) begin
            m_tuser  <= status_r;
            m_tdata  <= {4'b0000,
                         row_ok ? tab_q : {FREQ_W{1'b0}},
                         total,
                         (row_ok && col_ok) ? cell_q : {CNT_W{1'b0}},
                         row_ok ? res_q : {TS_W{1'b0}},
                         known ? SIDX_W'(cur) : {SIDX_W{1'b0}}};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `FRC_ASSERT(a_known_loaded, known |-> (EW'(cur) < count), "current state is not a loaded entry")
  `FRC_ASSERT(a_total_in_wb, (total != $past(total)) |-> ($past(state) == S_WB), "total moved outside write back")
  `FRC_ASSERT(a_out_from_rdw, $rose(m_tvalid) |-> ($past(state) == S_RDW), "result raised outside report state")
  `FRC_ASSERT(a_cell_after_rd, cnt_req.wb_cell |-> $past(cnt_req.rd), "cell write back without a read")
  `FRC_ASSERT_NEXT(a_rmw_order, (state == S_APPLY) && cnt_req.rd, state == S_WB, "counter read not followed by write back")

endmodule

`default_nettype wire
